// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ----- hdl/sdff_pkg.sv -----
// Types and constants for the signed decimal field formatter.
package sdff_pkg;

  localparam int VALUE_W = 18;
  localparam int MAG_W   = 17;
  localparam int CHAR_W  = 7;
  localparam int POS_W   = 3;

  localparam logic [MAG_W-1:0]  MAG_MAX  = 17'd99999;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [POS_W-1:0]  POS_SIGN = 3'd0;
  localparam logic [POS_W-1:0]  POS_LAST = 3'd5;

  // Digit weights for positions 1..5.
  localparam int WEIGHT [5] = '{10000, 1000, 100, 10, 1};

  // One classified item handed from front to back.
  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [MAG_W-1:0] mag;
  } item_t;

endpackage

// ----- hdl/sdff_front.sv -----
// Front end: sign, magnitude and clamp of one input value.
module sdff_front (
  input  logic signed [sdff_pkg::VALUE_W-1:0] value,
  output sdff_pkg::item_t                     item
);
  import sdff_pkg::*;

  logic [VALUE_W-1:0] mag_full;

  // Negation of the most negative value wraps to 0x20000, its true magnitude.
  assign mag_full = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

  always_comb begin
    item.neg = value[VALUE_W-1];
    item.sat = (mag_full > {1'b0, MAG_MAX});
    item.mag = item.sat ? MAG_MAX : mag_full[MAG_W-1:0];
  end

endmodule

// ----- hdl/sdff_queue.sv -----
// Small FIFO of classified items between front and back.
module sdff_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  sdff_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd_en,
  output sdff_pkg::item_t rd_item,
  output logic            not_empty
);
  import sdff_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/sdff_back.sv -----
// Back end: emits sign then five blanked digits, one character per cycle unless the result port stalls.
module sdff_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  sdff_pkg::item_t              head_item,
  output logic                         head_take,
  output logic [sdff_pkg::CHAR_W-1:0]  ascii_char,
  output logic [sdff_pkg::POS_W-1:0]   char_position,
  output logic                         last_char,
  output logic                         saturated,
  output logic                         empty,
  input  logic                         pop
);
  import sdff_pkg::*;

  logic             busy;
  logic [POS_W-1:0] pos;
  logic [MAG_W-1:0] rem;
  logic             nz;
  logic             sat;
  logic             out_valid;
  logic             advance;

  logic [MAG_W-1:0] mult [1:9];
  logic [3:0]       digit;
  logic [MAG_W-1:0] sub_val;
  logic [MAG_W-1:0] rem_next;
  logic             nz_next;
  logic [CHAR_W-1:0] dig_char;

  assign advance   = !out_valid || pop;
  assign head_take = advance && !busy && head_valid;
  assign empty     = !out_valid;

  // Multiples of the current position's weight.
  always_comb begin
    for (int k = 1; k < 10; k++) begin
      case (pos)
        3'd1:    mult[k] = MAG_W'(k * WEIGHT[0]);
        3'd2:    mult[k] = MAG_W'(k * WEIGHT[1]);
        3'd3:    mult[k] = MAG_W'(k * WEIGHT[2]);
        3'd4:    mult[k] = MAG_W'(k * WEIGHT[3]);
        default: mult[k] = MAG_W'(k * WEIGHT[4]);
      endcase
    end
  end

  // Digit = largest k with k*w <= remainder.
  always_comb begin
    digit   = 4'd0;
    sub_val = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= mult[k]) begin
        digit   = 4'(k);
        sub_val = mult[k];
      end
    end
    rem_next = rem - sub_val;
    nz_next  = nz || (digit != 4'd0);
    dig_char = (nz_next || pos == POS_LAST) ? (CH_ZERO + CHAR_W'(digit)) : CH_SPACE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (busy) begin
        out_valid <= 1'b1;
        busy      <= (pos != POS_LAST);
      end else begin
        out_valid <= head_valid;
        busy      <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        ascii_char    <= dig_char;
        char_position <= pos;
        last_char     <= (pos == POS_LAST);
        saturated     <= sat;
        pos           <= pos + POS_W'(1);
        rem           <= rem_next;
        nz            <= nz_next;
      end else if (head_valid) begin
        ascii_char    <= head_item.neg ? CH_MINUS : CH_SPACE;
        char_position <= POS_SIGN;
        last_char     <= 1'b0;
        saturated     <= head_item.sat;
        pos           <= POS_SIGN + POS_W'(1);
        rem           <= head_item.mag;
        nz            <= 1'b0;
        sat           <= head_item.sat;
      end
    end
  end

endmodule

// ----- hdl/signed_decimal_field_formatter.sv -----
// Top level of the signed decimal field formatter.
// Each value pushed in becomes six ASCII characters, popped one at a time in
// position order: position 0 is '-' or a space, positions 1..5 are the decimal
// digits of the magnitude with leading zeros shown as spaces (the units digit
// always prints). Magnitudes above 99999 print as 99999 and flag saturated on
// all six characters. The result port delivers one character per transfer, so
// it sets the throughput; with pop held high and a value queued, the fields of
// successive values follow without stalling. A pushed value is written into
// the queue, and its sign character is then registered into the result port
// from the queue head. A small queue of QUEUE_DEPTH classified values lets the
// input side keep taking transfers while the result side stalls.
module signed_decimal_field_formatter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [sdff_pkg::VALUE_W-1:0] value,
  output logic                                empty,
  input  logic                                pop,
  output logic [sdff_pkg::CHAR_W-1:0]         ascii_char,
  output logic [sdff_pkg::POS_W-1:0]          char_position,
  output logic                                last_char,
  output logic                                saturated
);
  import sdff_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  head_valid;
  logic  head_take;
  logic  wr_en;

  // Input transfer writes straight into the queue.
  assign wr_en = push && !full;

  // Sign, magnitude and clamp.
  sdff_front u_front (
    .value (value),
    .item  (front_item)
  );

  // Decouples classification from character emission.
  sdff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_item   (front_item),
    .full      (full),
    .rd_en     (head_take),
    .rd_item   (head_item),
    .not_empty (head_valid)
  );

  // Digit extraction, blanking and the registered result port.
  sdff_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .head_take     (head_take),
    .ascii_char    (ascii_char),
    .char_position (char_position),
    .last_char     (last_char),
    .saturated     (saturated),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

// ----- hdl/sdff_checker.sv -----
// Port-level checks of the formatter, bound to the top level.
`include "assert_macros.svh"

module sdff_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                empty,
  input logic                                pop,
  input logic [sdff_pkg::CHAR_W-1:0]         ascii_char,
  input logic [sdff_pkg::POS_W-1:0]          char_position,
  input logic                                last_char,
  input logic                                saturated
);
  import sdff_pkg::*;

  // A stalled result holds.
  `ASSERT_NEXT(a_hold, !empty && !pop,
    !empty && $stable(ascii_char) && $stable(char_position), "stalled result changed")

  // Last flag marks position five, and minus appears only at the sign.
  `ASSERT_CLK(a_last, empty || ((last_char == (char_position == POS_LAST)) &&
    (ascii_char != CH_MINUS || char_position == POS_SIGN)), "bad last flag or sign placement")

  // Digits follow each other in position order within a field.
  `ASSERT_NEXT(a_order, !empty && pop && char_position != POS_LAST,
    !empty && char_position == $past(char_position) + 3'd1 &&
    saturated == $past(saturated), "field sequence broken")

  // Only space, minus and digits are produced.
  `ASSERT_CLK(a_chars, empty || ascii_char == CH_SPACE || ascii_char == CH_MINUS ||
    (ascii_char >= CH_ZERO && ascii_char <= CH_ZERO + 7'd9), "illegal character")

endmodule

bind signed_decimal_field_formatter sdff_checker u_sdff_checker (.*);
